// File: rtl/core/dfa_longest_prefix_matcher_defines.svh
// Assertion macros shared by the matcher's checker.
`ifndef DFA_LONGEST_PREFIX_MATCHER_DEFINES_SVH
`define DFA_LONGEST_PREFIX_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DLPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DLPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked through reset.
`define DLPM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/dlpm_pkg.sv
// Shared types and constants of the automaton prefix matcher.
package dlpm_pkg;

   localparam int STATE_COUNT_DEF  = 64;
   localparam int SYMBOL_COUNT_DEF = 32;
   localparam int LENGTH_LIMIT_DEF = 65535;

   localparam int STATE_FIELD_W  = 6;
   localparam int SYMBOL_FIELD_W = 5;
   localparam int BYTE_W         = 8;
   localparam int BYTE_COUNT     = 256;
   localparam int LENGTH_OUT_W   = 16;

   localparam logic [LENGTH_OUT_W-1:0] MATCH_LENGTH_MAX = 16'hFFFF;

   localparam int RSP_FIFO_DEPTH = 8;

   typedef enum logic [1:0] {
      MODE_TRANS  = 2'd0,
      MODE_MAP    = 2'd1,
      MODE_ACCEPT = 2'd2,
      MODE_TEXT   = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic [STATE_FIELD_W-1:0]  state_index;
      logic [SYMBOL_FIELD_W-1:0] symbol_class;
      logic [STATE_FIELD_W-1:0]  target_state;
      logic [BYTE_W-1:0]         byte_value;
      logic                      flag_value;
      logic                      last_byte;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [LENGTH_OUT_W-1:0] match_length;
      logic                    whole_accepted;
      logic                    hit_unknown_byte;
   } rsp_type;

   // Text byte after the symbol map lookup.
   typedef struct packed {
      logic text;
      logic last;
      logic mapped;
   } text_ctl_type;

   // Text byte after the state step, handed to the scoring stage.
   typedef struct packed {
      logic text;
      logic last;
      logic at_start;
      logic stopped_before;
      logic stopped_after;
   } walk_ctl_type;

endpackage

// File: rtl/core/dfa_longest_prefix_matcher.sv
// Top level of the table-driven automaton longest-prefix matcher.
// Accepts one transaction per clock while req_stall is low: table writes
// (transition, symbol map, accepting flag) and text bytes share the request
// channel. Each text byte passes the symbol map, walker and scorer registers
// on its way to the result queue, and bytes overlap fully; the rate is bounded
// by the state loop, where the registered output of the transition memory is
// the next lookup address. A byte marked last yields one result transaction.
// After reset, req_stall stays high while the accepting flags of all states
// are cleared; the initial-state register can be written during that time.
// req_stall also rises when the eight-entry result queue could fill.
module dfa_longest_prefix_matcher #(
   parameter int STATE_COUNT  = dlpm_pkg::STATE_COUNT_DEF,
   parameter int SYMBOL_COUNT = dlpm_pkg::SYMBOL_COUNT_DEF,
   parameter int LENGTH_LIMIT = dlpm_pkg::LENGTH_LIMIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dlpm_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dlpm_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dlpm_pkg::STATE_FIELD_W-1:0] csr_data
);
   import dlpm_pkg::*;

   localparam int STATE_W = $clog2(STATE_COUNT);
   localparam int SYM_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int POS_W   = $clog2(LENGTH_LIMIT + 1);
   localparam int CNT_W   = $clog2(RSP_FIFO_DEPTH + 1);

   logic [STATE_FIELD_W-1:0] init_state_ff, init_state_in;
   logic                     req_accept, clear_busy, s3_last, rsp_push;
   text_ctl_type             s1_ctl;
   logic [SYM_W-1:0]         s1_sym;
   walk_ctl_type             s2_ctl;
   logic [POS_W-1:0]         s2_pos_before, s2_pos_after;
   logic [STATE_W-1:0]       look_addr, final_addr;
   rsp_type                  rsp_data;
   logic [CNT_W-1:0]         fifo_count;
   logic [CNT_W:0]           reserved;

   always_comb begin
      init_state_in = csr_valid ? csr_data : init_state_ff;
      // Every last byte still in the pipeline holds a queue slot.
      reserved  = (CNT_W + 1)'(fifo_count)
                + (CNT_W + 1)'(s1_ctl.text && s1_ctl.last)
                + (CNT_W + 1)'(s2_ctl.text && s2_ctl.last)
                + (CNT_W + 1)'(s3_last);
      req_stall = clear_busy || (reserved >= (CNT_W + 1)'(RSP_FIFO_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_state_ff <= '0;
      end else begin
         init_state_ff <= init_state_in;
      end
   end

   assign csr_ready  = 1'b1;
   assign req_accept = req_valid && !req_stall;

   dlpm_symbol_map #(
      .SYMBOL_COUNT(SYMBOL_COUNT)
   ) u_symbol_map (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req        (req_payload),
      .s1_ctl     (s1_ctl),
      .s1_sym     (s1_sym)
   );

   dlpm_walker #(
      .STATE_COUNT  (STATE_COUNT),
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .LENGTH_LIMIT (LENGTH_LIMIT)
   ) u_walker (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req           (req_payload),
      .init_state    (init_state_ff),
      .s1_ctl        (s1_ctl),
      .s1_sym        (s1_sym),
      .s2_ctl        (s2_ctl),
      .s2_pos_before (s2_pos_before),
      .s2_pos_after  (s2_pos_after),
      .look_addr     (look_addr),
      .final_addr    (final_addr)
   );

   dlpm_scorer #(
      .STATE_COUNT  (STATE_COUNT),
      .LENGTH_LIMIT (LENGTH_LIMIT)
   ) u_scorer (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req           (req_payload),
      .s2_ctl        (s2_ctl),
      .s2_pos_before (s2_pos_before),
      .s2_pos_after  (s2_pos_after),
      .look_addr     (look_addr),
      .final_addr    (final_addr),
      .clear_busy    (clear_busy),
      .s3_last       (s3_last),
      .rsp_push      (rsp_push),
      .rsp_data      (rsp_data)
   );

   dlpm_rsp_fifo #(
      .DEPTH(RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .pop       (!rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .count     (fifo_count)
   );

endmodule

// File: rtl/core/dlpm_symbol_map.sv
// Byte-to-symbol map memory with per-byte valid bits; first pipeline stage.
module dlpm_symbol_map #(
   parameter int SYMBOL_COUNT = dlpm_pkg::SYMBOL_COUNT_DEF,
   localparam int SYM_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  dlpm_pkg::req_type      req,
   output dlpm_pkg::text_ctl_type s1_ctl,
   output logic [SYM_W-1:0]       s1_sym
);
   import dlpm_pkg::*;

   logic [SYM_W-1:0]      map_mem [BYTE_COUNT];
   logic [BYTE_COUNT-1:0] valid_ff, valid_in;
   logic [SYM_W-1:0]      sym_ff;
   text_ctl_type          ctl_ff, ctl_in;
   logic [31:0]           class_ext;
   logic                  map_write;

   always_comb begin
      class_ext = 32'(req.symbol_class);
      map_write = req_accept && (req.mode == MODE_MAP) && (class_ext < SYMBOL_COUNT);
      valid_in = valid_ff;
      if (map_write) begin
         valid_in[req.byte_value] = req.flag_value;
      end
      ctl_in.text   = req_accept && (req.mode == MODE_TEXT);
      ctl_in.last   = req.last_byte;
      ctl_in.mapped = valid_ff[req.byte_value];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ctl_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ctl_ff   <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (map_write) begin
         map_mem[req.byte_value] <= class_ext[SYM_W-1:0];
      end
      sym_ff <= map_mem[req.byte_value];
   end

   assign s1_ctl = ctl_ff;
   assign s1_sym = sym_ff;

endmodule

// File: rtl/core/dlpm_walker.sv
// Transition memory and the automaton state loop, with position tracking.
module dlpm_walker #(
   parameter int STATE_COUNT  = dlpm_pkg::STATE_COUNT_DEF,
   parameter int SYMBOL_COUNT = dlpm_pkg::SYMBOL_COUNT_DEF,
   parameter int LENGTH_LIMIT = dlpm_pkg::LENGTH_LIMIT_DEF,
   localparam int STATE_W = $clog2(STATE_COUNT),
   localparam int SYM_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1,
   localparam int POS_W   = $clog2(LENGTH_LIMIT + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_accept,
   input  dlpm_pkg::req_type                    req,
   input  logic [dlpm_pkg::STATE_FIELD_W-1:0]   init_state,
   input  dlpm_pkg::text_ctl_type               s1_ctl,
   input  logic [SYM_W-1:0]                     s1_sym,
   output dlpm_pkg::walk_ctl_type               s2_ctl,
   output logic [POS_W-1:0]                     s2_pos_before,
   output logic [POS_W-1:0]                     s2_pos_after,
   output logic [STATE_W-1:0]                   look_addr,
   output logic [STATE_W-1:0]                   final_addr
);
   import dlpm_pkg::*;

   localparam int TRANS_DEPTH = STATE_COUNT * (1 << SYM_W);

   logic [STATE_W-1:0] trans_mem [TRANS_DEPTH];
   logic [STATE_W-1:0] trans_rdata_ff;

   logic               pending_ff, pending_in;
   logic [STATE_W-1:0] hold_ff, hold_in;
   logic               at_start_ff, at_start_in;
   logic               stopped_ff, stopped_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   walk_ctl_type       s2_ctl_ff, s2_ctl_in;
   logic [POS_W-1:0]   s2_before_ff, s2_before_in;
   logic [POS_W-1:0]   s2_after_ff, s2_after_in;

   logic [31:0]        init_ext, st_ext, cls_ext, tgt_ext;
   logic [STATE_W-1:0] init_clamped, state_now, cur_state;
   logic               stopped_before, advance, trans_write;
   logic [POS_W-1:0]   pos_before;
   logic [STATE_W+SYM_W-1:0] trans_waddr, trans_raddr;

   always_comb begin
      init_ext     = 32'(init_state);
      init_clamped = (init_ext < STATE_COUNT) ? init_ext[STATE_W-1:0] : '0;
      // The registered memory output is the state whenever the last byte advanced.
      state_now      = pending_ff ? trans_rdata_ff : hold_ff;
      cur_state      = at_start_ff ? init_clamped : state_now;
      stopped_before = !at_start_ff && stopped_ff;
      pos_before     = at_start_ff ? '0 : pos_ff;
      advance        = s1_ctl.text && !stopped_before && s1_ctl.mapped;
      trans_raddr    = {cur_state, s1_sym};

      pending_in  = advance;
      hold_in     = s1_ctl.text ? cur_state : state_now;
      at_start_in = s1_ctl.text ? s1_ctl.last : at_start_ff;
      stopped_in  = s1_ctl.text ? (stopped_before || !s1_ctl.mapped) : stopped_ff;
      if (s1_ctl.text) begin
         if (advance && (pos_before < POS_W'(LENGTH_LIMIT))) begin
            pos_in = pos_before + 1'b1;
         end else begin
            pos_in = pos_before;
         end
      end else begin
         pos_in = pos_ff;
      end

      s2_ctl_in.text           = s1_ctl.text;
      s2_ctl_in.last           = s1_ctl.last;
      s2_ctl_in.at_start       = at_start_ff;
      s2_ctl_in.stopped_before = stopped_before;
      s2_ctl_in.stopped_after  = stopped_in;
      s2_before_in             = pos_before;
      s2_after_in              = pos_in;

      st_ext      = 32'(req.state_index);
      cls_ext     = 32'(req.symbol_class);
      tgt_ext     = 32'(req.target_state);
      trans_write = req_accept && (req.mode == MODE_TRANS) && (st_ext < STATE_COUNT)
                    && (cls_ext < SYMBOL_COUNT) && (tgt_ext < STATE_COUNT);
      trans_waddr = {st_ext[STATE_W-1:0], cls_ext[SYM_W-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 1'b0;
         hold_ff     <= '0;
         at_start_ff <= 1'b1;
         stopped_ff  <= 1'b0;
         pos_ff      <= '0;
         s2_ctl_ff   <= '0;
      end else begin
         pending_ff  <= pending_in;
         hold_ff     <= hold_in;
         at_start_ff <= at_start_in;
         stopped_ff  <= stopped_in;
         pos_ff      <= pos_in;
         s2_ctl_ff   <= s2_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_before_ff <= s2_before_in;
      s2_after_ff  <= s2_after_in;
   end

   // Reads return the old entry when a write to it lands on the same edge.
   always_ff @(posedge clock) begin
      if (trans_write) begin
         trans_mem[trans_waddr] <= tgt_ext[STATE_W-1:0];
      end
      if (advance) begin
         trans_rdata_ff <= trans_mem[trans_raddr];
      end
   end

   assign s2_ctl        = s2_ctl_ff;
   assign s2_pos_before = s2_before_ff;
   assign s2_pos_after  = s2_after_ff;
   assign look_addr     = cur_state;
   assign final_addr    = state_now;

endmodule

// File: rtl/core/dlpm_scorer.sv
// Accepting-flag memory, longest-prefix bookkeeping and result formation.
module dlpm_scorer #(
   parameter int STATE_COUNT  = dlpm_pkg::STATE_COUNT_DEF,
   parameter int LENGTH_LIMIT = dlpm_pkg::LENGTH_LIMIT_DEF,
   localparam int STATE_W = $clog2(STATE_COUNT),
   localparam int POS_W   = $clog2(LENGTH_LIMIT + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  dlpm_pkg::req_type      req,
   input  dlpm_pkg::walk_ctl_type s2_ctl,
   input  logic [POS_W-1:0]       s2_pos_before,
   input  logic [POS_W-1:0]       s2_pos_after,
   input  logic [STATE_W-1:0]     look_addr,
   input  logic [STATE_W-1:0]     final_addr,
   output logic                   clear_busy,
   output logic                   s3_last,
   output logic                   rsp_push,
   output dlpm_pkg::rsp_type      rsp_data
);
   import dlpm_pkg::*;

   logic               acc_mem [STATE_COUNT];
   logic               look_rd_ff, final_rd_ff;

   logic               clear_busy_ff, clear_busy_in;
   logic [STATE_W-1:0] clear_idx_ff, clear_idx_in;
   logic               acc_wr_en_ff, acc_wr_en_in;
   logic [STATE_W-1:0] acc_wr_addr_ff, acc_wr_addr_in;
   logic               acc_wr_flag_ff, acc_wr_flag_in;
   logic               found_ff, found_in;
   logic [POS_W-1:0]   best_ff, best_in;
   logic               s3_valid_ff, s3_valid_in;
   logic               s3_stopped_ff, s3_stopped_in;
   logic [POS_W-1:0]   s3_pos_ff, s3_pos_in;

   logic [31:0]        st_ext, best_ext;
   logic               found_base, hit, whole;
   logic [POS_W-1:0]   best_base, best_final;

   always_comb begin
      clear_busy_in = clear_busy_ff && (clear_idx_ff != STATE_W'(STATE_COUNT - 1));
      clear_idx_in  = clear_idx_ff + 1'b1;

      // Flag writes pass through a register before they land, so the end-of-string
      // lookup never sees a write from a later transaction.
      st_ext         = 32'(req.state_index);
      acc_wr_en_in   = req_accept && (req.mode == MODE_ACCEPT) && (st_ext < STATE_COUNT);
      acc_wr_addr_in = st_ext[STATE_W-1:0];
      acc_wr_flag_in = req.flag_value;

      found_base = !s2_ctl.at_start && found_ff;
      best_base  = s2_ctl.at_start ? '0 : best_ff;
      hit        = s2_ctl.text && !s2_ctl.stopped_before && look_rd_ff;
      found_in   = s2_ctl.text ? (found_base || hit) : found_ff;
      best_in    = s2_ctl.text ? (hit ? s2_pos_before : best_base) : best_ff;

      s3_valid_in   = s2_ctl.text && s2_ctl.last;
      s3_stopped_in = s2_ctl.stopped_after;
      s3_pos_in     = s2_pos_after;

      // found_ff and best_ff still hold this string's totals here.
      whole      = s3_valid_ff && !s3_stopped_ff && final_rd_ff;
      best_final = whole ? s3_pos_ff : best_ff;
      best_ext   = 32'(best_final);

      rsp_data.found            = found_ff || whole;
      rsp_data.match_length     = (best_ext > 32'(MATCH_LENGTH_MAX)) ? MATCH_LENGTH_MAX
                                                                     : best_ext[LENGTH_OUT_W-1:0];
      rsp_data.whole_accepted   = whole;
      rsp_data.hit_unknown_byte = s3_stopped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
         acc_wr_en_ff  <= 1'b0;
         found_ff      <= 1'b0;
         best_ff       <= '0;
         s3_valid_ff   <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_idx_ff  <= clear_idx_in;
         acc_wr_en_ff  <= acc_wr_en_in;
         found_ff      <= found_in;
         best_ff       <= best_in;
         s3_valid_ff   <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_wr_addr_ff <= acc_wr_addr_in;
      acc_wr_flag_ff <= acc_wr_flag_in;
      s3_stopped_ff  <= s3_stopped_in;
      s3_pos_ff      <= s3_pos_in;
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         acc_mem[clear_idx_ff] <= 1'b0;
      end else if (acc_wr_en_ff) begin
         acc_mem[acc_wr_addr_ff] <= acc_wr_flag_ff;
      end
      look_rd_ff  <= acc_mem[look_addr];
      final_rd_ff <= acc_mem[final_addr];
   end

   assign clear_busy = clear_busy_ff;
   assign s3_last    = s3_valid_ff;
   assign rsp_push   = s3_valid_ff;

endmodule

// File: rtl/core/dlpm_rsp_fifo.sv
// Result queue that decouples the matcher pipeline from the result stall.
module dlpm_rsp_fifo #(
   parameter int DEPTH = dlpm_pkg::RSP_FIFO_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dlpm_pkg::rsp_type push_data,
   input  logic              pop,
   output logic              out_valid,
   output dlpm_pkg::rsp_type out_data,
   output logic [CNT_W-1:0]  count
);
   import dlpm_pkg::*;

   rsp_type          entry_mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_mem[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_mem[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// File: rtl/core/dlpm_checker.sv
// Port-level checker for the matcher, bound to the top level.
`include "dfa_longest_prefix_matcher_defines.svh"

module dlpm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input dlpm_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dlpm_pkg::rsp_type rsp_payload
);
   import dlpm_pkg::*;

   // The accepting-flag clearing pass must hold off requests right after reset.
   `DLPM_ASSERT_NEXT_ALWAYS(a_stall_after_reset, clock, reset, req_stall, "request taken during clearing pass")

   `DLPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result changed")

   // A whole-string match is a found match and cannot follow an unmapped byte.
   `DLPM_ASSERT_NOW(a_whole_consistent, clock, reset, rsp_valid && rsp_payload.whole_accepted, rsp_payload.found && !rsp_payload.hit_unknown_byte, "inconsistent result fields")

   // A result that starts an empty queue comes from an accepted last text byte.
   `DLPM_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall && (req_payload.mode == MODE_TEXT) && req_payload.last_byte, 4), "result without a last text byte")

endmodule

bind dfa_longest_prefix_matcher dlpm_checker u_dlpm_checker (.*);

// File: sim/dfa_longest_prefix_matcher_test.sv
// Self-checking testbench for the automaton longest-prefix matcher.
`timescale 1ns / 1ps

module dfa_longest_prefix_matcher_test;
   import dlpm_pkg::*;

   localparam int WATCHDOG_LIMIT    = 4000;
   localparam int DRAIN_CYCLES      = 8;
   localparam int PHASE_ITEMS       = 120;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type result;
   } stim_row_type;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_EVERY_THIRD, STALL_COIN, STALL_HEAVY
   } stall_style_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;
   logic    csr_valid   = 1'b0;
   logic    csr_ready;
   logic [STATE_FIELD_W-1:0] csr_data = '0;

   // Mirror of the matcher's tables and walk state.
   bit [STATE_FIELD_W-1:0]  next_state_of [0:STATE_COUNT_DEF*SYMBOL_COUNT_DEF-1];
   bit                      entry_written [0:STATE_COUNT_DEF*SYMBOL_COUNT_DEF-1];
   bit [SYMBOL_FIELD_W-1:0] class_of_byte [0:BYTE_COUNT-1];
   bit                      byte_mapped   [0:BYTE_COUNT-1];
   bit                      state_accepts [0:STATE_COUNT_DEF-1];
   bit [STATE_FIELD_W-1:0]  start_state  = '0;
   bit [STATE_FIELD_W-1:0]  walk_state   = '0;
   int unsigned             walk_position = 0;
   int unsigned             longest_prefix = 0;
   bit                      any_accept   = 1'b0;
   bit                      halted       = 1'b0;
   bit                      string_fresh = 1'b1;

   rsp_type expected_results[$];

   logic [STATE_FIELD_W-1:0] state_pool [8];
   logic [BYTE_W-1:0]        byte_pool  [10];

   int unsigned items_sent       = 0;
   int unsigned results_checked  = 0;
   int unsigned settings_written = 0;
   int unsigned fail_count       = 0;
   int unsigned burst_left       = 0;
   int unsigned idle_cycles      = 0;
   int unsigned stall_left       = 0;
   stall_style_type stall_style  = STALL_NONE;

   dfa_longest_prefix_matcher dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advances the mirrored matcher by one request; returns 1 when a result is due.
   function automatic bit step_matcher(input req_type item, output rsp_type outcome);
      outcome = '0;
      case (item.mode)
         MODE_TRANS: begin
            next_state_of[{item.state_index, item.symbol_class}] = item.target_state;
            entry_written[{item.state_index, item.symbol_class}] = 1'b1;
            return 1'b0;
         end
         MODE_MAP: begin
            class_of_byte[item.byte_value] = item.symbol_class;
            byte_mapped[item.byte_value]   = item.flag_value;
            return 1'b0;
         end
         MODE_ACCEPT: begin
            state_accepts[item.state_index] = item.flag_value;
            return 1'b0;
         end
         default: begin
            if (string_fresh) begin
               walk_state     = start_state;
               walk_position  = 0;
               longest_prefix = 0;
               any_accept     = 1'b0;
               halted         = 1'b0;
               string_fresh   = 1'b0;
            end
            if (!halted) begin
               if (state_accepts[walk_state]) begin
                  any_accept     = 1'b1;
                  longest_prefix = walk_position;
               end
               if (!byte_mapped[item.byte_value]) begin
                  halted = 1'b1;
               end else begin
                  walk_state = next_state_of[{walk_state, class_of_byte[item.byte_value]}];
                  if (walk_position < LENGTH_LIMIT_DEF) walk_position++;
               end
            end
            if (!item.last_byte) return 1'b0;
            if (!halted && state_accepts[walk_state]) begin
               outcome.whole_accepted = 1'b1;
               any_accept     = 1'b1;
               longest_prefix = walk_position;
            end
            outcome.found            = any_accept;
            outcome.match_length     = (longest_prefix > 65535) ? MATCH_LENGTH_MAX
                                                               : longest_prefix[15:0];
            outcome.hit_unknown_byte = halted;
            string_fresh = 1'b1;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic req_type random_fields();
      logic [31:0] noise;
      noise = $urandom;
      return noise[$bits(req_type)-1:0];
   endfunction

   function automatic stim_row_type make_row(input mode_type m, input logic [5:0] st,
                                             input logic [4:0] sym, input logic [5:0] tgt,
                                             input logic [7:0] b, input logic f,
                                             input logic l, input logic typed = 1'b0,
                                             input rsp_type r = '0);
      stim_row_type row;
      row.item = '{m, st, sym, tgt, b, f, l};
      row.typed  = typed;
      row.result = r;
      return row;
   endfunction

   task automatic put_request(input req_type item, input logic typed, input rsp_type typed_result);
      rsp_type outcome;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      if (step_matcher(item, outcome))
         expected_results = {expected_results, (typed ? typed_result : outcome)};
   endtask

   task automatic pace_sender();
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 20);
      end
      burst_left--;
   endtask

   // A text byte must never walk into a transition entry that was never written,
   // so such an entry is filled in just ahead of the byte.
   task automatic send_request(input req_type item, input logic typed = 1'b0,
                               input rsp_type typed_result = '0);
      req_type patch;
      logic [STATE_FIELD_W-1:0] from;
      pace_sender();
      if (item.mode == MODE_TEXT && (string_fresh || !halted)
          && byte_mapped[item.byte_value]) begin
         from = string_fresh ? start_state : walk_state;
         if (!entry_written[{from, class_of_byte[item.byte_value]}]) begin
            patch = random_fields();
            patch.mode         = MODE_TRANS;
            patch.state_index  = from;
            patch.symbol_class = class_of_byte[item.byte_value];
            patch.target_state = state_pool[$urandom_range(0, 7)];
            put_request(patch, 1'b0, '0);
         end
      end
      put_request(item, typed, typed_result);
   endtask

   // Holds the sender until every expected result has come and the pipeline is empty.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_start_state(input logic [STATE_FIELD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      start_state = value;
      settings_written++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(input int unsigned quota);
      req_type item;
      logic [SYMBOL_FIELD_W-1:0] class_pool [4];
      int unsigned done;
      int unsigned span;
      state_pool[0] = start_state;
      for (int k = 1; k < 8; k++) state_pool[k] = 6'($urandom_range(0, 63));
      for (int k = 0; k < 4; k++) class_pool[k] = 5'($urandom_range(0, 31));
      for (int k = 0; k < 10; k++) byte_pool[k] = 8'($urandom_range(0, 255));
      done = 0;
      // Build a small automaton over a few states and bytes so that strings walk deep.
      for (int k = 0; k < 10; k++) begin
         item = random_fields();
         item.mode         = MODE_MAP;
         item.byte_value   = byte_pool[k];
         item.symbol_class = class_pool[$urandom_range(0, 3)];
         item.flag_value   = ($urandom_range(0, 9) != 0);
         send_request(item);
         done++;
      end
      for (int k = 0; k < 8; k++) begin
         item = random_fields();
         item.mode        = MODE_ACCEPT;
         item.state_index = state_pool[k];
         send_request(item);
         done++;
      end
      for (int k = 0; k < 12; k++) begin
         item = random_fields();
         item.mode         = MODE_TRANS;
         item.state_index  = state_pool[$urandom_range(0, 7)];
         item.symbol_class = class_pool[$urandom_range(0, 3)];
         item.target_state = state_pool[$urandom_range(0, 7)];
         send_request(item);
         done++;
      end
      while (done < quota) begin
         span = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
         for (int k = 0; k < span; k++) begin
            if ($urandom_range(0, 15) == 0) begin
               item = random_fields();
               item.mode = mode_type'($urandom_range(0, 2));
               send_request(item);
               done++;
            end
            item = random_fields();
            item.mode       = MODE_TEXT;
            item.byte_value = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                          : byte_pool[$urandom_range(0, 9)];
            item.last_byte  = (k == span - 1);
            send_request(item);
            done++;
         end
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         results_checked++;
         if (expected_results.size() == 0) begin
            $error("result transaction arrived with no expectation pending");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.found !== want.found) begin
               $error("found mismatch: expected %0d, actual %0d", want.found, rsp_payload.found);
               fail_count++;
            end
            if (rsp_payload.match_length !== want.match_length) begin
               $error("match_length mismatch: expected %0d, actual %0d",
                      want.match_length, rsp_payload.match_length);
               fail_count++;
            end
            if (rsp_payload.whole_accepted !== want.whole_accepted) begin
               $error("whole_accepted mismatch: expected %0d, actual %0d",
                      want.whole_accepted, rsp_payload.whole_accepted);
               fail_count++;
            end
            if (rsp_payload.hit_unknown_byte !== want.hit_unknown_byte) begin
               $error("hit_unknown_byte mismatch: expected %0d, actual %0d",
                      want.hit_unknown_byte, rsp_payload.hit_unknown_byte);
               fail_count++;
            end
         end
      end
   end

   // The receiver switches to a randomly chosen stall style whenever its style counter runs out.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_left  <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         STALL_NONE:        rsp_stall <= 1'b0;
         STALL_EVERY_THIRD: rsp_stall <= (stall_left % 3 == 0);
         STALL_COIN:        rsp_stall <= 1'($urandom_range(0, 1));
         default:           rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
          || (csr_valid && csr_ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      stim_row_type directed_rows[$];
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_start_state('0);

      // Empty tables, accepting flags, prefix records, halted strings and mid-string writes.
      directed_rows = {directed_rows, make_row(MODE_TEXT, 0, 0, 0, 8'h00, 0, 1, 1,
                                               rsp_type'{1'b0, 16'd0, 1'b0, 1'b1})};
      directed_rows = {directed_rows, make_row(MODE_ACCEPT, 0, 0, 0, 8'h00, 1, 0)};
      directed_rows = {directed_rows, make_row(MODE_TEXT, 63, 31, 63, 8'hFF, 1, 1, 1,
                                               rsp_type'{1'b1, 16'd0, 1'b0, 1'b1})};
      directed_rows = {directed_rows, make_row(MODE_MAP, 0, 31, 0, 8'h41, 1, 0)};
      directed_rows = {directed_rows, make_row(MODE_MAP, 0, 0, 0, 8'hFF, 1, 0)};
      directed_rows = {directed_rows, make_row(MODE_TRANS, 0, 31, 63, 8'h00, 0, 0)};
      directed_rows = {directed_rows, make_row(MODE_TRANS, 63, 0, 1, 8'h00, 0, 0)};
      directed_rows = {directed_rows, make_row(MODE_ACCEPT, 63, 0, 0, 8'h00, 1, 0)};
      directed_rows = {directed_rows, make_row(MODE_TEXT, 0, 0, 0, 8'h41, 0, 1, 1,
                                               rsp_type'{1'b1, 16'd1, 1'b1, 1'b0})};
      directed_rows = {directed_rows, make_row(MODE_TEXT, 0, 0, 0, 8'h41, 0, 0)};
      directed_rows = {directed_rows, make_row(MODE_TEXT, 0, 0, 0, 8'hFF, 0, 1, 1,
                                               rsp_type'{1'b1, 16'd1, 1'b0, 1'b0})};
      directed_rows = {directed_rows, make_row(MODE_ACCEPT, 0, 0, 0, 8'h00, 0, 0)};
      // A write with last_byte set must not yield a result.
      directed_rows = {directed_rows, make_row(MODE_TRANS, 0, 0, 0, 8'hFF, 1, 1)};
      directed_rows = {directed_rows, make_row(MODE_TEXT, 0, 0, 0, 8'hFF, 0, 1, 1,
                                               rsp_type'{1'b0, 16'd0, 1'b0, 1'b0})};
      directed_rows = {directed_rows, make_row(MODE_TEXT, 0, 0, 0, 8'h41, 0, 0)};
      directed_rows = {directed_rows, make_row(MODE_TEXT, 0, 0, 0, 8'h00, 0, 0)};
      directed_rows = {directed_rows, make_row(MODE_TEXT, 0, 0, 0, 8'h41, 0, 1, 1,
                                               rsp_type'{1'b1, 16'd1, 1'b0, 1'b1})};
      directed_rows = {directed_rows, make_row(MODE_TEXT, 0, 0, 0, 8'h41, 0, 0)};
      directed_rows = {directed_rows, make_row(MODE_ACCEPT, 63, 0, 0, 8'h00, 0, 0)};
      directed_rows = {directed_rows, make_row(MODE_MAP, 0, 0, 0, 8'h41, 0, 0)};
      directed_rows = {directed_rows, make_row(MODE_TEXT, 0, 0, 0, 8'h41, 0, 1, 1,
                                               rsp_type'{1'b0, 16'd0, 1'b0, 1'b1})};
      foreach (directed_rows[i])
         send_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

      for (int p = 0; p < 5; p++) begin
         settle();
         write_start_state((p == 0) ? 6'd63 : (p == 2) ? 6'd0 : 6'($urandom_range(0, 63)));
         run_random_phase(PHASE_ITEMS);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request transactions and checked %0d result transactions",
               items_sent, results_checked);
      $display("over directed table cases and random automata under %0d initial states.",
               settings_written);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/dlpm_pkg.sv
rtl/core/dlpm_symbol_map.sv
rtl/core/dlpm_walker.sv
rtl/core/dlpm_scorer.sv
rtl/core/dlpm_rsp_fifo.sv
rtl/core/dfa_longest_prefix_matcher.sv
rtl/core/dlpm_checker.sv
sim/dfa_longest_prefix_matcher_test.sv
